// ===== hw/rtl/drc_pkg.sv =====
package drc_pkg;

  // Configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_POS_X   = 3'd0;
  localparam logic [2:0] REG_POS_Y   = 3'd1;
  localparam logic [2:0] REG_DIR_X   = 3'd2;
  localparam logic [2:0] REG_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_PLANE_X = 3'd4;
  localparam logic [2:0] REG_PLANE_Y = 3'd5;

  // Item op codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // Wall codes with a colour of their own
  localparam logic [2:0] CODE_RED   = 3'd1;
  localparam logic [2:0] CODE_GREEN = 3'd2;
  localparam logic [2:0] CODE_BLUE  = 3'd3;
  localparam logic [2:0] CODE_WHITE = 3'd4;

  // Shared divider
  localparam int DIV_W  = 42;
  localparam int ITER_W = 6;

  // Significant bits of the camera product slice, and dividend bits of each division
  localparam int CAM_BITS   = 26;
  localparam int DELTA_BITS = 33;
  localparam int PERP_BITS  = 41;
  localparam int LH_BITS    = 29;

  // Shared multiplier operands
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 29;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIV_W-1:0]  divisor;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/drc_in_if.sv =====
interface drc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [4:0] cell_x;
  logic [4:0] cell_y;
  logic [2:0] cell_value;
  logic [8:0] column;

  modport source (output valid, op, cell_x, cell_y, cell_value, column, input ready);
  modport sink   (input valid, op, cell_x, cell_y, cell_value, column, output ready);
endinterface

// ===== hw/rtl/drc_out_if.sv =====
interface drc_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] out_column;
  logic [7:0] draw_start;
  logic [7:0] draw_end;
  logic [2:0] wall_code;
  logic       hit_side;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       no_hit;

  modport source (output valid, out_column, draw_start, draw_end, wall_code, hit_side,
                  red, green, blue, no_hit, input ready);
  modport sink   (input valid, out_column, draw_start, draw_end, wall_code, hit_side,
                  red, green, blue, no_hit, output ready);
endinterface

// ===== hw/rtl/drc_ram.sv =====
module drc_ram #(
  parameter int Width = 3,
  parameter int Depth = 1024,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hw/rtl/drc_div.sv =====
module drc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  drc_pkg::div_req_t  req_i,
  output drc_pkg::div_rsp_t  rsp_o,
  output logic               busy_o
);
  import drc_pkg::*;

  logic              busy_q, done_q;
  logic [ITER_W-1:0] cnt_q;
  logic [DIV_W-1:0]  rem_q, dvd_q, dsr_q, quo_q;
  logic [DIV_W-1:0]  trial;
  logic              fits;

  // One quotient bit per cycle, dividend left-aligned on its MSB
  assign trial = {rem_q[DIV_W-2:0], dvd_q[DIV_W-1]};
  assign fits  = (trial >= dsr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ITER_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? trial - dsr_q : trial;
      dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign busy_o         = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule

// ===== hw/rtl/drc_mul.sv =====
module drc_mul (
  input  logic                                clk_i,
  input  logic signed [drc_pkg::MUL_A_W-1:0]  a_i,
  input  logic signed [drc_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [drc_pkg::MUL_P_W-1:0]  prod_o
);
  import drc_pkg::*;

  always_ff @(posedge clk_i) begin
    prod_o <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end
endmodule

// ===== hw/rtl/dda_raycast_column.sv =====
// Grid ray caster: one screen column per cast item.
// A cast item goes through the bit-serial shared divider (up to four divisions: two step lengths,
// the wall distance and the line height) and a grid read per DDA step, and no new item is
// accepted until it is through; the result waits in an output register until taken.
// Reset is asynchronous and active low; after it the grid is cleared one cell a cycle until all
// GRID_SIZE * GRID_SIZE cells are clear, during which no item is accepted.
module dda_raycast_column #(
  parameter int GRID_SIZE   = 32,
  parameter int SCREEN_COLS = 320,
  parameter int SCREEN_ROWS = 200,
  parameter int MAX_STEPS   = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  drc_in_if.sink                      req_i,
  drc_out_if.source                   rsp_o,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [drc_pkg::APB_AW-1:0]  paddr_i,
  input  logic [drc_pkg::APB_DW-1:0]  pwdata_i,
  output logic [drc_pkg::APB_DW-1:0]  prdata_o,
  output logic                        pready_o
);
  import drc_pkg::*;

  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int AW        = $clog2(CELLS);
  localparam int MW        = $clog2((GRID_SIZE > 32) ? GRID_SIZE : 32) + 2;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int DX_W      = 41;
  localparam int SD_W      = DX_W + STEP_W + 1;
  localparam int NUM_W     = MW + 17;
  localparam int RAY_W     = 31;
  localparam int CAM_W     = 28;
  localparam int LH_W      = 31;
  localparam int HALF_ROWS = SCREEN_ROWS / 2;
  localparam int CAM_SHIFT = CAM_BITS + $clog2(SCREEN_COLS);
  localparam longint CAM_RECIP =
    ((longint'(1) << CAM_SHIFT) + longint'(SCREEN_COLS) - 1) / longint'(SCREEN_COLS);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CAM, S_MULX, S_MULY, S_RY, S_DXS, S_DXW, S_DYS, S_DYW,
    S_SDX, S_SDY, S_SDYW, S_WALK, S_LOOK, S_PS, S_PW, S_LS, S_LW, S_FIN
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [20:0]        pos_x_q, pos_y_q;
  logic signed [17:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

  logic cfg_wr;
  assign cfg_wr   = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= 21'd1441792;
      pos_y_q   <= 21'd786432;
      dir_x_q   <= -18'sd65536;
      dir_y_q   <= '0;
      plane_x_q <= '0;
      plane_y_q <= 18'sd43254;
    end else if (cfg_wr) begin
      case (paddr_i[4:2])
        REG_POS_X:   pos_x_q   <= pwdata_i[20:0];
        REG_POS_Y:   pos_y_q   <= pwdata_i[20:0];
        REG_DIR_X:   dir_x_q   <= $signed(pwdata_i[17:0]);
        REG_DIR_Y:   dir_y_q   <= $signed(pwdata_i[17:0]);
        REG_PLANE_X: plane_x_q <= $signed(pwdata_i[17:0]);
        REG_PLANE_Y: plane_y_q <= $signed(pwdata_i[17:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr_i[4:2])
      REG_POS_X:   prdata_o = APB_DW'(pos_x_q);
      REG_POS_Y:   prdata_o = APB_DW'(pos_y_q);
      REG_DIR_X:   prdata_o = APB_DW'(dir_x_q);
      REG_DIR_Y:   prdata_o = APB_DW'(dir_y_q);
      REG_PLANE_X: prdata_o = APB_DW'(plane_x_q);
      REG_PLANE_Y: prdata_o = APB_DW'(plane_y_q);
      default:     prdata_o = '0;
    endcase
  end

  // Working registers
  logic [AW-1:0]           clr_q;
  logic [8:0]              column_q;
  logic signed [CAM_W-1:0] cam_q;
  logic signed [RAY_W-1:0] rx_q, ry_q;
  logic [DX_W-1:0]         dx_q, dy_q;
  logic                    dx_sat_q, dy_sat_q;
  logic [SD_W-1:0]         sdx_q, sdy_q;
  logic signed [MW-1:0]    mx_q, my_q;
  logic [STEP_W-1:0]       steps_q;
  logic                    side_q, nohit_q;
  logic [2:0]              code_q;
  logic [DX_W-1:0]         perp_q;
  logic [LH_W-1:0]         lh_q;
  logic                    rsp_valid_q;

  // Output registers
  logic [8:0] o_column_q;
  logic [7:0] o_start_q, o_end_q, o_red_q, o_green_q, o_blue_q;
  logic [2:0] o_code_q;
  logic       o_side_q, o_nohit_q;

  // Shared units
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     div_busy;

  drc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp),
    .busy_o (div_busy)
  );

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  drc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [2:0]    ram_wdata, ram_rdata;

  drc_ram #(.Width(3), .Depth(CELLS)) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Handshake
  logic in_xfer, cast_xfer, out_free;
  assign req_i.ready = (state_q == S_IDLE);
  assign in_xfer     = req_i.valid & req_i.ready;
  assign cast_xfer   = in_xfer & (req_i.op == OP_CAST);
  assign out_free    = !rsp_valid_q | rsp_o.ready;

  // Ray setup terms
  logic        rx_neg, ry_neg;
  logic [16:0] frac_x, frac_y;
  assign rx_neg = rx_q[RAY_W-1];
  assign ry_neg = ry_q[RAY_W-1];
  assign frac_x = rx_neg ? {1'b0, pos_x_q[15:0]} : 17'h10000 - {1'b0, pos_x_q[15:0]};
  assign frac_y = ry_neg ? {1'b0, pos_y_q[15:0]} : 17'h10000 - {1'b0, pos_y_q[15:0]};

  logic [RAY_W-1:0] abs_rx, abs_ry;
  assign abs_rx = rx_neg ? -rx_q : rx_q;
  assign abs_ry = ry_neg ? -ry_q : ry_q;

  // DDA step
  logic                 take_x, in_grid;
  logic signed [MW-1:0] nmx, nmy;
  logic [AW-1:0]        walk_addr;
  assign take_x  = (sdx_q < sdy_q);
  assign nmx     = take_x ? (rx_neg ? mx_q - 1'b1 : mx_q + 1'b1) : mx_q;
  assign nmy     = take_x ? my_q : (ry_neg ? my_q - 1'b1 : my_q + 1'b1);
  assign in_grid = !nmx[MW-1] && !nmy[MW-1] &&
                   (nmx < MW'(GRID_SIZE)) && (nmy < MW'(GRID_SIZE));
  assign walk_addr = AW'(AW'(nmx[MW-2:0]) * AW'(GRID_SIZE) + AW'(nmy[MW-2:0]));

  // Distance to the crossed boundary
  logic signed [MW-1:0]    bnd;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        num_abs;
  logic [RAY_W-1:0]        ray_abs;
  assign bnd     = side_q ? my_q + MW'(ry_neg) : mx_q + MW'(rx_neg);
  assign num     = (NUM_W'(bnd) <<< 16) -
                   $signed({1'b0, (NUM_W-1)'(side_q ? pos_y_q : pos_x_q)});
  assign num_abs = num[NUM_W-1] ? -num : num;
  assign ray_abs = side_q ? abs_ry : abs_rx;

  // Slice rows and colour
  logic [LH_W-2:0] lh_half;
  logic [LH_W-1:0] de_full;
  logic [7:0]      ds_row, de_row, red_c, green_c, blue_c;
  assign lh_half = lh_q[LH_W-1:1];
  assign de_full = LH_W'(lh_half) + LH_W'(HALF_ROWS);
  assign ds_row  = (lh_half >= (LH_W-1)'(HALF_ROWS)) ? 8'd0
                 : 8'((LH_W-1)'(HALF_ROWS) - lh_half);
  assign de_row  = (de_full >= LH_W'(SCREEN_ROWS)) ? 8'(SCREEN_ROWS - 1) : 8'(de_full);

  always_comb begin
    red_c   = 8'd0;
    green_c = 8'd0;
    blue_c  = 8'd0;
    case (code_q)
      CODE_RED:   red_c = 8'd255;
      CODE_GREEN: green_c = 8'd255;
      CODE_BLUE:  blue_c = 8'd255;
      CODE_WHITE: begin
        red_c   = 8'd255;
        green_c = 8'd255;
        blue_c  = 8'd255;
      end
      default: begin
        red_c   = 8'd255;
        green_c = 8'd255;
      end
    endcase
    if (side_q) begin
      red_c   = red_c >> 1;
      green_c = green_c >> 1;
      blue_c  = blue_c >> 1;
    end
  end

  // Unit operands
  always_comb begin
    div_req = '0;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      S_IDLE: begin
        // column over screen width by reciprocal, exact for every 9-bit column
        mul_a = MUL_A_W'(req_i.column);
        mul_b = MUL_B_W'(CAM_RECIP);
      end
      S_MULX: begin
        mul_a = MUL_A_W'(plane_x_q);
        mul_b = MUL_B_W'(cam_q);
      end
      S_MULY: begin
        mul_a = MUL_A_W'(plane_y_q);
        mul_b = MUL_B_W'(cam_q);
      end
      S_DXS, S_DYS: begin
        div_req.start    = (state_q == S_DXS) ? (rx_q != '0) : (ry_q != '0);
        div_req.dividend = DIV_W'(1) << (DIV_W - 1);
        div_req.divisor  = DIV_W'((state_q == S_DXS) ? abs_rx : abs_ry);
        div_req.iters    = ITER_W'(DELTA_BITS);
      end
      S_SDX: begin
        mul_a = $signed({1'b0, dx_q[32:0]});
        mul_b = $signed(MUL_B_W'(frac_x));
      end
      S_SDY: begin
        mul_a = $signed({1'b0, dy_q[32:0]});
        mul_b = $signed(MUL_B_W'(frac_y));
      end
      S_PS: begin
        div_req.start    = (ray_abs != '0);
        div_req.dividend = (DIV_W'(num_abs) << 16) << (DIV_W - PERP_BITS);
        div_req.divisor  = DIV_W'(ray_abs);
        div_req.iters    = ITER_W'(PERP_BITS);
      end
      S_LS: begin
        div_req.start    = (perp_q != '0);
        div_req.dividend = (DIV_W'(SCREEN_ROWS) << 16) << (DIV_W - LH_BITS);
        div_req.divisor  = DIV_W'(perp_q);
        div_req.iters    = ITER_W'(LH_BITS);
      end
      default: ;
    endcase
  end

  // Grid port
  logic cell_ok;
  assign cell_ok = (int'(req_i.cell_x) < GRID_SIZE) && (int'(req_i.cell_y) < GRID_SIZE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = 3'd0;
    if (state_q == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (in_xfer && req_i.op == OP_WRITE && cell_ok) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(AW'(req_i.cell_x) * AW'(GRID_SIZE) + AW'(req_i.cell_y));
      ram_wdata = req_i.cell_value;
    end
  end
  assign ram_raddr = walk_addr;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (state_q == S_FIN && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(CELLS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cast_xfer) begin
            column_q <= req_i.column;
            state_q  <= S_CAM;
          end
        end
        S_CAM: begin
          cam_q   <= $signed({2'b00, prod[CAM_SHIFT-17 +: CAM_BITS]}) - CAM_W'(65536);
          state_q <= S_MULX;
        end
        S_MULX: state_q <= S_MULY;
        S_MULY: begin
          rx_q    <= RAY_W'(dir_x_q) + $signed(prod[RAY_W+15:16]);
          state_q <= S_RY;
        end
        S_RY: begin
          ry_q    <= RAY_W'(dir_y_q) + $signed(prod[RAY_W+15:16]);
          state_q <= S_DXS;
        end
        S_DXS: begin
          if (rx_q == '0) begin
            dx_q     <= DX_W'(1) << 40;
            dx_sat_q <= 1'b1;
            state_q  <= S_DYS;
          end else begin
            state_q <= S_DXW;
          end
        end
        S_DXW: begin
          if (div_rsp.done) begin
            dx_q     <= DX_W'(div_rsp.quotient[DELTA_BITS-1:0]);
            dx_sat_q <= 1'b0;
            state_q  <= S_DYS;
          end
        end
        S_DYS: begin
          if (ry_q == '0) begin
            dy_q     <= DX_W'(1) << 40;
            dy_sat_q <= 1'b1;
            state_q  <= S_SDX;
          end else begin
            state_q <= S_DYW;
          end
        end
        S_DYW: begin
          if (div_rsp.done) begin
            dy_q     <= DX_W'(div_rsp.quotient[DELTA_BITS-1:0]);
            dy_sat_q <= 1'b0;
            state_q  <= S_SDX;
          end
        end
        S_SDX: state_q <= S_SDY;
        S_SDY: begin
          sdx_q   <= dx_sat_q ? SD_W'({frac_x, 24'd0}) : SD_W'(prod[48:16]);
          state_q <= S_SDYW;
        end
        S_SDYW: begin
          sdy_q   <= dy_sat_q ? SD_W'({frac_y, 24'd0}) : SD_W'(prod[48:16]);
          mx_q    <= MW'(pos_x_q[20:16]);
          my_q    <= MW'(pos_y_q[20:16]);
          steps_q <= '0;
          nohit_q <= 1'b0;
          side_q  <= 1'b0;
          state_q <= S_WALK;
        end
        S_WALK: begin
          if (steps_q == STEP_W'(MAX_STEPS)) begin
            nohit_q <= 1'b1;
            state_q <= S_FIN;
          end else begin
            steps_q <= steps_q + 1'b1;
            mx_q    <= nmx;
            my_q    <= nmy;
            if (take_x) begin
              sdx_q  <= sdx_q + SD_W'(dx_q);
              side_q <= 1'b0;
            end else begin
              sdy_q  <= sdy_q + SD_W'(dy_q);
              side_q <= 1'b1;
            end
            if (!in_grid) begin
              nohit_q <= 1'b1;
              state_q <= S_FIN;
            end else begin
              state_q <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          code_q  <= ram_rdata;
          state_q <= (ram_rdata != 3'd0) ? S_PS : S_WALK;
        end
        S_PS: begin
          if (ray_abs == '0) begin
            perp_q  <= DX_W'(1) << 40;
            state_q <= S_LS;
          end else begin
            state_q <= S_PW;
          end
        end
        S_PW: begin
          if (div_rsp.done) begin
            perp_q  <= div_rsp.quotient[DX_W-1:0];
            state_q <= S_LS;
          end
        end
        S_LS: begin
          if (perp_q == '0) begin
            lh_q    <= LH_W'(1) << 30;
            state_q <= S_FIN;
          end else begin
            state_q <= S_LW;
          end
        end
        S_LW: begin
          if (div_rsp.done) begin
            lh_q    <= div_rsp.quotient[LH_W-1:0];
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            o_column_q  <= column_q;
            o_nohit_q   <= nohit_q;
            o_start_q   <= nohit_q ? 8'd0 : ds_row;
            o_end_q     <= nohit_q ? 8'd0 : de_row;
            o_code_q    <= nohit_q ? 3'd0 : code_q;
            o_side_q    <= nohit_q ? 1'b0 : side_q;
            o_red_q     <= nohit_q ? 8'd0 : red_c;
            o_green_q   <= nohit_q ? 8'd0 : green_c;
            o_blue_q    <= nohit_q ? 8'd0 : blue_c;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.out_column = o_column_q;
  assign rsp_o.draw_start = o_start_q;
  assign rsp_o.draw_end   = o_end_q;
  assign rsp_o.wall_code  = o_code_q;
  assign rsp_o.hit_side   = o_side_q;
  assign rsp_o.red        = o_red_q;
  assign rsp_o.green      = o_green_q;
  assign rsp_o.blue       = o_blue_q;
  assign rsp_o.no_hit     = o_nohit_q;

  // Checks
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  a_grid_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR || state_q == S_IDLE))
    else $error("grid written during a cast");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == S_FIN)
    else $error("result raised outside the finish step");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DXW || state_q == S_DYW ||
                      state_q == S_PW || state_q == S_LW))
    else $error("quotient arrived with no waiting step");
endmodule

// ===== tb/dda_raycast_column_tb.sv =====
module dda_raycast_column_tb;
  import drc_pkg::*;

  localparam int GRID      = 32;
  localparam int COLS      = 320;
  localparam int ROWS      = 200;
  localparam int STEP_MAX  = 64;
  localparam int IDLE_PCT  = 24;
  localparam int STALL_MAX = 20000;
  localparam int RAND_ITEMS = 1000;
  localparam int PHASES     = 8;

  typedef struct packed {
    logic [8:0] column;
    logic [7:0] row_top;
    logic [7:0] row_bot;
    logic [2:0] code;
    logic       side;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       miss;
  } slice_t;

  class slice_board;
    logic [2:0] walls [GRID*GRID];
    longint     pos_x, pos_y, dir_x, dir_y, plane_x, plane_y;
    slice_t     pending_q[$];
    int         errors, casts, writes, hits, misses;

    function new();
      foreach (walls[k]) walls[k] = '0;
      pos_x = 1441792; pos_y = 786432;
      dir_x = -65536; dir_y = 0; plane_x = 0; plane_y = 43254;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_POS_X:   pos_x   = longint'(v[20:0]);
        REG_POS_Y:   pos_y   = longint'(v[20:0]);
        REG_DIR_X:   dir_x   = longint'($signed(v[17:0]));
        REG_DIR_Y:   dir_y   = longint'($signed(v[17:0]));
        REG_PLANE_X: plane_x = longint'($signed(v[17:0]));
        REG_PLANE_Y: plane_y = longint'($signed(v[17:0]));
        default: ;
      endcase
    endfunction

    function longint step_len(longint ray);
      longint a;
      a = (ray < 0) ? -ray : ray;
      return (a == 0) ? (longint'(1) << 40) : ((longint'(1) << 32) / a);
    endfunction

    function slice_t cast_slice(logic [8:0] col);
      longint cam, rx, ry, dx, dy, sdx, sdy, num, ray, perp, lh, ds, de;
      int     mx, my, sx, sy, side, code;
      bit     hit;
      slice_t s;
      s = '0;
      side = 0; code = 0; hit = 0;
      cam = (2 * longint'(col) * 65536) / COLS - 65536;
      rx = dir_x + ((plane_x * cam) >>> 16);
      ry = dir_y + ((plane_y * cam) >>> 16);
      dx = step_len(rx);
      dy = step_len(ry);
      mx = int'(pos_x >> 16);
      my = int'(pos_y >> 16);
      sx = (rx < 0) ? -1 : 1;
      sy = (ry < 0) ? -1 : 1;
      sdx = (rx < 0) ? (((pos_x - (longint'(mx) << 16)) * dx) >>> 16)
                     : ((((longint'(mx) + 1) << 16) - pos_x) * dx) >>> 16;
      sdy = (ry < 0) ? (((pos_y - (longint'(my) << 16)) * dy) >>> 16)
                     : ((((longint'(my) + 1) << 16) - pos_y) * dy) >>> 16;
      // the start square is never tested
      for (int n = 0; n < STEP_MAX; n++) begin
        if (sdx < sdy) begin
          sdx += dx; mx += sx; side = 0;
        end else begin
          sdy += dy; my += sy; side = 1;
        end
        if (mx < 0 || mx >= GRID || my < 0 || my >= GRID) break;
        code = walls[mx*GRID + my];
        if (code != 0) begin
          hit = 1;
          break;
        end
      end
      s.column = col;
      if (!hit) begin
        s.miss = 1'b1;
        return s;
      end
      if (side == 0) begin
        num = (longint'(mx + (sx < 0 ? 1 : 0)) << 16) - pos_x;
        ray = rx;
      end else begin
        num = (longint'(my + (sy < 0 ? 1 : 0)) << 16) - pos_y;
        ray = ry;
      end
      if (num < 0) num = -num;
      if (ray < 0) ray = -ray;
      perp = (ray == 0) ? (longint'(1) << 40) : ((num << 16) / ray);
      lh = (perp == 0) ? (longint'(1) << 30) : ((longint'(ROWS) * 65536) / perp);
      ds = ROWS/2 - lh/2;
      if (ds < 0) ds = 0;
      de = lh/2 + ROWS/2;
      if (de >= ROWS) de = ROWS - 1;
      s.row_top = ds[7:0];
      s.row_bot = de[7:0];
      s.code = code[2:0];
      s.side = side[0];
      case (code[2:0])
        CODE_RED:   s.red = 8'd255;
        CODE_GREEN: s.green = 8'd255;
        CODE_BLUE:  s.blue = 8'd255;
        CODE_WHITE: begin
          s.red = 8'd255; s.green = 8'd255; s.blue = 8'd255;
        end
        default: begin
          s.red = 8'd255; s.green = 8'd255;
        end
      endcase
      if (s.side) begin
        s.red = s.red >> 1; s.green = s.green >> 1; s.blue = s.blue >> 1;
      end
      return s;
    endfunction

    function void note_item(logic op, logic [4:0] cx, logic [4:0] cy,
                            logic [2:0] val, logic [8:0] col);
      slice_t s;
      if (op == OP_WRITE) begin
        walls[int'(cx)*GRID + int'(cy)] = val;
        writes++;
      end else begin
        s = cast_slice(col);
        pending_q.push_back(s);
        casts++;
        if (s.miss) misses++; else hits++;
      end
    endfunction

    task report(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_slice(slice_t got);
      slice_t w;
      if (pending_q.size() == 0) begin
        report("unexpected slice, column", got.column, -1);
        return;
      end
      w = pending_q.pop_front();
      if (got.column  !== w.column)  report("out_column", got.column, w.column);
      if (got.row_top !== w.row_top) report("draw_start", got.row_top, w.row_top);
      if (got.row_bot !== w.row_bot) report("draw_end", got.row_bot, w.row_bot);
      if (got.code    !== w.code)    report("wall_code", got.code, w.code);
      if (got.side    !== w.side)    report("hit_side", got.side, w.side);
      if (got.red     !== w.red)     report("red", got.red, w.red);
      if (got.green   !== w.green)   report("green", got.green, w.green);
      if (got.blue    !== w.blue)    report("blue", got.blue, w.blue);
      if (got.miss    !== w.miss)    report("no_hit", got.miss, w.miss);
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel_i, penable_i, pwrite_i;
  logic [APB_AW-1:0] paddr_i;
  logic [APB_DW-1:0] pwdata_i;
  logic [APB_DW-1:0] prdata_o;
  logic              pready_o;
  bit                calm;
  int                stall_cnt;

  drc_in_if  req();
  drc_out_if rsp();

  slice_board board = new();

  dda_raycast_column i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rsp_o     (rsp),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp.ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready)
      board.check_slice('{rsp.out_column, rsp.draw_start, rsp.draw_end, rsp.wall_code,
                          rsp.hit_side, rsp.red, rsp.green, rsp.blue, rsp.no_hit});
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (psel_i && penable_i))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt == STALL_MAX) begin
      $display("watchdog expired after %0d idle cycles", STALL_MAX);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    @(negedge clk_i);
    psel_i = 1'b1; penable_i = 1'b0; pwrite_i = 1'b1;
    paddr_i = {idx, 2'b00}; pwdata_i = v;
    @(negedge clk_i);
    penable_i = 1'b1;
    do @(posedge clk_i); while (!pready_o);
    board.set_reg(idx, v);
    @(negedge clk_i);
    psel_i = 1'b0; penable_i = 1'b0;
  endtask

  task automatic send_item(logic op, logic [4:0] cx, logic [4:0] cy,
                           logic [2:0] val, logic [8:0] col);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk_i);
      req.valid = 1'b0;
    end
    @(negedge clk_i);
    req.valid = 1'b1; req.op = op; req.cell_x = cx; req.cell_y = cy;
    req.cell_value = val; req.column = col;
    do @(posedge clk_i); while (!req.ready);
    board.note_item(op, cx, cy, val, col);
  endtask

  task automatic drain();
    @(negedge clk_i);
    req.valid = 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic load_view(logic [20:0] px, logic [20:0] py, logic [17:0] dx,
                           logic [17:0] dy, logic [17:0] qx, logic [17:0] qy);
    reg_write(REG_POS_X, 32'(px));
    reg_write(REG_POS_Y, 32'(py));
    reg_write(REG_DIR_X, 32'(dx));
    reg_write(REG_DIR_Y, 32'(dy));
    reg_write(REG_PLANE_X, 32'(qx));
    reg_write(REG_PLANE_Y, 32'(qy));
  endtask

  initial begin
    logic [20:0] px, py;
    logic [17:0] dx, dy, qx, qy;
    logic [8:0]  probe_cols [7];
    stall_cnt = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    psel_i = 1'b0; penable_i = 1'b0; pwrite_i = 1'b0; paddr_i = '0; pwdata_i = '0;
    req.valid = 1'b0; req.op = OP_WRITE; req.cell_x = '0; req.cell_y = '0;
    req.cell_value = '0; req.column = '0;
    probe_cols = '{9'd0, 9'd319, 9'd511, 9'd100, 9'd200, 9'd255, 9'd480};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    load_view(21'd1441792, 21'd786432, -18'sd65536, 18'd0, 18'd0, 18'd43254);
    // center column has a zero y component; empty grid gives no wall
    send_item(OP_CAST, 5'd0, 5'd0, 3'd0, 9'd160);
    // wall right next to a viewer standing on a boundary: zero distance
    send_item(OP_WRITE, 5'd21, 5'd12, 3'd1, 9'd0);
    send_item(OP_CAST, 5'd0, 5'd0, 3'd0, 9'd160);
    send_item(OP_WRITE, 5'd21, 5'd12, 3'd0, 9'd0);
    for (int k = 0; k < 9; k++)
      send_item(OP_WRITE, 5'd10, 5'(4 + 2*k), 3'(1 + k % 7), 9'd0);
    send_item(OP_WRITE, 5'd31, 5'd31, 3'd7, 9'd0);
    send_item(OP_WRITE, 5'd0, 5'd0, 3'd6, 9'd0);
    for (int k = 0; k < 7; k++)
      send_item(OP_CAST, 5'd0, 5'd0, 3'd0, probe_cols[k]);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph == 3);
      case (ph)
        0: load_view(21'd0, 21'd0, 18'h20000, 18'h20000, 18'h20000, 18'h20000);
        1: load_view(21'h1FFFFF, 21'h1FFFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
        default: begin
          px = 21'($urandom_range(1 << 16, (31 << 16) - 1));
          py = 21'($urandom_range(1 << 16, (31 << 16) - 1));
          dx = 18'($urandom); dy = 18'($urandom);
          qx = 18'($urandom); qy = 18'($urandom);
          load_view(px, py, dx, dy, qx, qy);
        end
      endcase
      for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
        if ($urandom_range(0, 99) < 30)
          send_item(OP_WRITE, 5'($urandom), 5'($urandom),
                    ($urandom_range(0, 3) == 0) ? 3'd0 : 3'($urandom_range(1, 7)), 9'd0);
        else
          send_item(OP_CAST, 5'($urandom), 5'($urandom), 3'($urandom),
                    ($urandom_range(0, 9) == 0) ? 9'($urandom_range(320, 511))
                                                : 9'($urandom_range(0, 319)));
      end
      drain();
    end
    calm = 1'b0;
    repeat (400) @(posedge clk_i);

    $display("Ran %0d casts (%0d walls hit, %0d open) and %0d grid writes",
             board.casts, board.hits, board.misses, board.writes);
    $display("over %0d view settings, extremes included", PHASES + 1);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d slices never seen", board.errors, board.pending_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
